/* design/ptcr_pkg.sv */
// shared types and constants of the packed triangle cell reader
package ptcr_pkg;

    // field widths
    localparam int WORD_W   = 64;
    localparam int IDX_W    = 12;
    localparam int RC_W     = 6;
    localparam int ORDER_W  = 7;
    localparam int FACTOR_W = ORDER_W + 1;
    localparam int PROD_W   = RC_W + FACTOR_W;
    localparam int POOL_W   = 2 * ORDER_W - 1;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_MODE = 1'b0;
    localparam reg_idx_t REG_SIZE = 1'b1;

    // action field codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // layout modes
    localparam logic MODE_SYM  = 1'b0;
    localparam logic MODE_ASYM = 1'b1;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_WRITE      = 2'd0,
        OP_READ_MEM   = 2'd1,
        OP_READ_CONST = 2'd2
    } op_t;

    // live configuration as seen by the datapath
    typedef struct packed {
        logic                mode;
        logic [ORDER_W-1:0]  order;
        logic [POOL_W-1:0]   pool;
    } cfg_t;

    // one classified item waiting for the back end
    typedef struct packed {
        op_t                 op;
        logic [IDX_W-1:0]    index;
        logic [WORD_W-1:0]   word;
        logic [PROD_W-1:0]   prod;
        logic [RC_W-1:0]     offset;
        logic                flip;
        logic                err;
    } qent_t;

endpackage

/* design/ptcr_in_if.sv */
// input channel of the packed triangle cell reader
interface ptcr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [ptcr_pkg::IDX_W-1:0]    packed_index;
    logic [ptcr_pkg::WORD_W-1:0]   word;
    logic [ptcr_pkg::RC_W-1:0]     row;
    logic [ptcr_pkg::RC_W-1:0]     col;

    modport source (
        output valid, action, packed_index, word, row, col,
        input  ready
    );

    modport sink (
        input  valid, action, packed_index, word, row, col,
        output ready
    );
endinterface

/* design/ptcr_out_if.sv */
// result channel of the packed triangle cell reader
interface ptcr_out_if;
    logic                          valid;
    logic                          ready;
    logic [ptcr_pkg::WORD_W-1:0]   cell_value;
    logic                          range_error;

    modport source (
        output valid, cell_value, range_error,
        input  ready
    );

    modport sink (
        input  valid, cell_value, range_error,
        output ready
    );
endinterface

/* design/ptcr_ram.sv */
// generic simple dual port ram with registered read
module ptcr_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 2080,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/ptcr_cfg.sv */
// configuration registers with derived order and pool size
module ptcr_cfg #(
    parameter int MAX_ORDER = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ptcr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ptcr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ptcr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output ptcr_pkg::cfg_t                   cfg
);
    import ptcr_pkg::*;

    localparam int SAT       = (MAX_ORDER < 127) ? MAX_ORDER : 127;
    localparam int RST_ORDER = (64 > SAT) ? SAT : 64;
    localparam int RST_POOL  = RST_ORDER * (RST_ORDER + 1) / 2;

    logic                       mode_reg, mode_next;
    logic [ORDER_W-1:0]         size_reg, size_next;
    logic [ORDER_W-1:0]         order_reg, order_next;
    logic [POOL_W-1:0]          pool_reg, pool_next;
    logic [FACTOR_W-1:0]        factor;
    logic [ORDER_W+FACTOR_W-1:0] pool_prod;
    logic                       wr;
    reg_idx_t                   idx;

    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[APB_ADDR_W-1];
    assign pready = 1'b1;

    // register write decode
    always_comb
    begin
        mode_next = mode_reg;
        size_next = size_reg;
        if (wr)
        begin
            unique case (idx)
                REG_MODE: mode_next = pwdata[0];
                REG_SIZE: size_next = pwdata[ORDER_W-1:0];
                default:  mode_next = mode_reg;
            endcase
        end
    end

    // saturated order and pool size for the new settings
    always_comb
    begin
        order_next = (size_next > ORDER_W'(SAT)) ? ORDER_W'(SAT) : size_next;
        factor     = (mode_next == MODE_ASYM) ? ({1'b0, order_next} - FACTOR_W'(1))
                                              : ({1'b0, order_next} + FACTOR_W'(1));
        pool_prod  = (ORDER_W + FACTOR_W)'(order_next) * (ORDER_W + FACTOR_W)'(factor);
        pool_next  = POOL_W'(pool_prod >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SYM;
            size_reg  <= ORDER_W'(64);
            order_reg <= ORDER_W'(RST_ORDER);
            pool_reg  <= POOL_W'(RST_POOL);
        end
        else
        begin
            mode_reg  <= mode_next;
            size_reg  <= size_next;
            order_reg <= order_next;
            pool_reg  <= pool_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, mode_reg};
            REG_SIZE: prdata = {{(APB_DATA_W-ORDER_W){1'b0}}, size_reg};
            default:  prdata = '0;
        endcase
    end

    assign cfg.mode  = mode_reg;
    assign cfg.order = order_reg;
    assign cfg.pool  = pool_reg;

endmodule

/* design/ptcr_front.sv */
// front end: accepts items, classifies them and queues all but dropped writes for the back end
module ptcr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  ptcr_pkg::cfg_t  cfg,
    ptcr_in_if.sink         item,
    output ptcr_pkg::qent_t head,
    output logic            head_valid,
    input  logic            head_pop
);
    import ptcr_pkg::*;

    qent_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    qent_t               ent;
    logic                keep;
    logic                accept;
    logic                push;
    logic [RC_W-1:0]     lo, hi;
    logic                diag;
    logic [FACTOR_W-1:0] factor;

    assign item.ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign accept     = item.valid & item.ready;
    assign push       = accept & keep;

    // classify the incoming beat
    always_comb
    begin
        lo     = (item.row <= item.col) ? item.row : item.col;
        hi     = (item.row <= item.col) ? item.col : item.row;
        diag   = (item.row == item.col);
        factor = (cfg.mode == MODE_ASYM)
               ? ({cfg.order, 1'b0} - FACTOR_W'(lo) - FACTOR_W'(1))
               : ({cfg.order, 1'b1} - FACTOR_W'(lo));

        ent.index  = item.packed_index;
        ent.word   = item.word;
        ent.prod   = PROD_W'(lo) * PROD_W'(factor);
        ent.offset = hi - lo;
        ent.flip   = 1'b0;
        ent.err    = 1'b0;
        ent.op     = OP_READ_MEM;
        keep       = 1'b1;

        if (item.action == ACT_WRITE)
        begin
            ent.op = OP_WRITE;
            keep   = ({1'b0, item.packed_index} < cfg.pool);
        end
        else if (({1'b0, item.row} >= cfg.order) || ({1'b0, item.col} >= cfg.order))
        begin
            ent.op  = OP_READ_CONST;
            ent.err = 1'b1;
        end
        else if (cfg.mode == MODE_ASYM)
        begin
            if (diag)
            begin
                ent.op = OP_READ_CONST;
            end
            else
            begin
                ent.offset = hi - lo - RC_W'(1);
                ent.flip   = (item.row > item.col);
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= ent;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (head_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(head_pop);
        end
    end

    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != '0);

endmodule

/* design/ptcr_back.sv */
// back end: store access, result assembly and result buffer
module ptcr_back #(
    parameter  int DEPTH = 2080,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptcr_pkg::qent_t               head,
    input  logic                          head_valid,
    output logic                          head_pop,
    output logic                          ram_we,
    output logic [AW-1:0]                 ram_waddr,
    output logic [ptcr_pkg::WORD_W-1:0]   ram_wdata,
    output logic                          ram_re,
    output logic [AW-1:0]                 ram_raddr,
    input  logic [ptcr_pkg::WORD_W-1:0]   ram_rdata,
    ptcr_out_if.source                    result
);
    import ptcr_pkg::*;

    localparam int OB_DEPTH = 2;
    localparam int OB_PTR_W = 1;
    localparam int OB_CNT_W = 2;

    logic [WORD_W-1:0]   ob_value_reg [OB_DEPTH];
    logic                ob_err_reg   [OB_DEPTH];
    logic [OB_PTR_W-1:0] ob_wr_reg, ob_rd_reg;
    logic [OB_CNT_W-1:0] ob_cnt_reg;
    logic                ob_pop;
    logic                pend_valid_reg;
    logic                pend_ram_reg, pend_flip_reg, pend_err_reg;
    logic                room;
    logic                issue;
    logic                in_store;
    logic [PROD_W-1:0]   mem_addr;
    logic [WORD_W-1:0]   push_value;

    assign ob_pop = (ob_cnt_reg != '0) & result.ready;

    // address and issue decision
    always_comb
    begin
        room     = (({1'b0, ob_cnt_reg} - (OB_CNT_W + 1)'(ob_pop)
                    + (OB_CNT_W + 1)'(pend_valid_reg)) < (OB_CNT_W + 1)'(OB_DEPTH));
        mem_addr = (head.prod >> 1) + PROD_W'(head.offset);
        in_store = (32'(mem_addr) < 32'(DEPTH));
        head_pop = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        issue    = 1'b0;
        if (head_valid)
        begin
            case (head.op)
                OP_WRITE:
                begin
                    head_pop = 1'b1;
                    ram_we   = 1'b1;
                end
                OP_READ_MEM, OP_READ_CONST:
                begin
                    if (room)
                    begin
                        head_pop = 1'b1;
                        issue    = 1'b1;
                        ram_re   = (head.op == OP_READ_MEM) & in_store;
                    end
                end
                default:
                begin
                    head_pop = 1'b1;
                end
            endcase
        end
    end

    assign ram_waddr = AW'(head.index);
    assign ram_wdata = head.word;
    assign ram_raddr = AW'(mem_addr);

    // read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_ram_reg  <= ram_re;
            pend_flip_reg <= head.flip;
            pend_err_reg  <= head.err;
        end
    end

    // mirrored antisymmetric cells carry the sign bit inverted
    assign push_value = (pend_ram_reg ? ram_rdata : '0)
                      ^ {pend_flip_reg, {(WORD_W-1){1'b0}}};

    // result buffer storage
    always_ff @(posedge clk)
    begin
        if (pend_valid_reg)
        begin
            ob_value_reg[ob_wr_reg] <= push_value;
            ob_err_reg[ob_wr_reg]   <= pend_err_reg;
        end
    end

    // result buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg  <= '0;
            ob_rd_reg  <= '0;
            ob_cnt_reg <= '0;
        end
        else
        begin
            if (pend_valid_reg)
            begin
                ob_wr_reg <= ob_wr_reg + OB_PTR_W'(1);
            end
            if (ob_pop)
            begin
                ob_rd_reg <= ob_rd_reg + OB_PTR_W'(1);
            end
            ob_cnt_reg <= ob_cnt_reg + OB_CNT_W'(pend_valid_reg) - OB_CNT_W'(ob_pop);
        end
    end

    assign result.valid       = (ob_cnt_reg != '0);
    assign result.cell_value  = ob_value_reg[ob_rd_reg];
    assign result.range_error = ob_err_reg[ob_rd_reg];

endmodule

/* design/packed_triangle_cell_reader.sv */
// top level of the packed triangle cell reader
//
//  port     dir  beat contents                            handshake
//  item     in   action, packed_index, word, row, col     valid/ready
//  result   out  cell_value, range_error                  valid/ready
//  apb      in   mode (0x0), matrix_size (0x4)            psel/penable, pready
//
//  one item per cycle sustained while the result side takes results; a read beat
//  passes through the queue stage, the registered ram read and the result buffer
//  write beats and dropped writes give no result
//  reset clears control and configuration only; the store holds nothing defined
//  until written and has no clearing pass
//  a two-entry queue parts front and back, a two-entry buffer holds results, so
//  item ready falls only when the queue is full
module packed_triangle_cell_reader #(
    parameter int MAX_ORDER = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ptcr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ptcr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ptcr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    ptcr_in_if.sink                          item,
    ptcr_out_if.source                       result
);
    import ptcr_pkg::*;

    localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int AW    = $clog2(DEPTH);

    cfg_t              cfg;
    qent_t             head;
    logic              head_valid;
    logic              head_pop;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    // configuration registers
    ptcr_cfg #(
        .MAX_ORDER (MAX_ORDER)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // classification and queue
    ptcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    // store access and results
    ptcr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .result     (result)
    );

    // packed word store
    ptcr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

/* verif/testbench.sv */
// self-checking testbench of the packed triangle cell reader
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptcr_pkg::*;

    localparam int MAX_ORDER     = 64;
    localparam int STORE_DEPTH   = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int END_CYCLES    = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int FILL_WORDS    = 600;
    localparam int PHASE_ITEMS   = 70;
    localparam int READ_TRIES    = 16;
    localparam logic [WORD_W-1:0] SIGN_BIT = {1'b1, {(WORD_W - 1){1'b0}}};

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  packed_index;
        logic [WORD_W-1:0] word;
        logic [RC_W-1:0]   row;
        logic [RC_W-1:0]   col;
    } cell_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] cell_value;
        logic              range_error;
    } cell_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ptcr_in_if  item_bus ();
    ptcr_out_if result_bus ();

    packed_triangle_cell_reader #(
        .MAX_ORDER (MAX_ORDER)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_bus),
        .result  (result_bus)
    );

    // shadow copy of the layout registers and the packed store
    logic               cur_mode;
    logic [ORDER_W-1:0] cur_size;
    logic [WORD_W-1:0]  packed_words [STORE_DEPTH];
    bit                 word_written [STORE_DEPTH];
    cell_result_t       pending_cells [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit send_idling    = 1'b1;
    bit recv_idling    = 1'b1;
    int hold_request   = 0;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** packed_triangle_cell_reader: FAILED **");
            $finish;
        end
    end

    // matrix order after saturation
    function automatic int order_in_use();
        return (cur_size > MAX_ORDER) ? MAX_ORDER : int'(cur_size);
    endfunction

    // number of packed words the current layout holds
    function automatic int pool_words(input int n);
        if (n == 0)
            return 0;
        return (cur_mode == MODE_ASYM) ? n * (n - 1) / 2 : n * (n + 1) / 2;
    endfunction

    // packed word a cell read touches, or -1 when it touches none
    function automatic int cell_slot(input int r, input int c);
        int n;
        int lo;
        int hi;
        n = order_in_use();
        if (r >= n || c >= n)
            return -1;
        lo = (r <= c) ? r : c;
        hi = (r <= c) ? c : r;
        if (cur_mode == MODE_SYM)
            return lo * (2 * n - lo + 1) / 2 + hi - lo;
        if (lo == hi)
            return -1;
        return lo * (2 * n - lo - 1) / 2 + hi - lo - 1;
    endfunction

    // expected cell for a read beat under the current layout
    function automatic cell_result_t predict_cell_read(input cell_item_t it);
        cell_result_t res;
        int n;
        int lo;
        int hi;
        int base;
        n = order_in_use();
        res.cell_value  = '0;
        res.range_error = 1'b0;
        if (it.row >= n || it.col >= n)
            res.range_error = 1'b1;
        else
        begin
            lo = (it.row <= it.col) ? int'(it.row) : int'(it.col);
            hi = (it.row <= it.col) ? int'(it.col) : int'(it.row);
            if (cur_mode == MODE_SYM)
            begin
                base = lo * (2 * n - lo + 1) / 2;
                res.cell_value = packed_words[base + hi - lo];
            end
            else if (lo != hi)
            begin
                base = lo * (2 * n - lo - 1) / 2;
                res.cell_value = packed_words[base + hi - lo - 1];
                if (it.row > it.col)
                    res.cell_value ^= SIGN_BIT;
            end
        end
        return res;
    endfunction

    function automatic cell_item_t write_beat(input int idx, input logic [WORD_W-1:0] w);
        cell_item_t it;
        it = '0;
        it.action       = ACT_WRITE;
        it.packed_index = IDX_W'(idx);
        it.word         = w;
        return it;
    endfunction

    function automatic cell_item_t read_beat(input int r, input int c);
        cell_item_t it;
        it = '0;
        it.action = ACT_READ;
        it.row    = RC_W'(r);
        it.col    = RC_W'(c);
        return it;
    endfunction

    // random read, mostly inside the matrix, steered away from unwritten words
    function automatic cell_item_t random_read_item();
        cell_item_t it;
        int n;
        int slot;
        int tries;
        bit usable;
        n      = order_in_use();
        it     = read_beat(0, 0);
        usable = 1'b0;
        tries  = 0;
        while (!usable && tries < READ_TRIES)
        begin
            it.row = RC_W'($urandom());
            it.col = RC_W'($urandom());
            if (n > 0 && $urandom_range(0, 4) != 0)
            begin
                it.row = RC_W'($urandom_range(0, n - 1));
                it.col = RC_W'($urandom_range(0, n - 1));
                if ($urandom_range(0, 7) == 0)
                    it.col = it.row;
            end
            slot   = cell_slot(int'(it.row), int'(it.col));
            usable = (slot < 0) || word_written[slot];
            tries++;
        end
        // cell (0, 0) is safe in every layout once word zero is written
        if (!usable)
            it = read_beat(0, 0);
        return it;
    endfunction

    // random beat, mostly inside the current pool and matrix
    function automatic cell_item_t random_cell_item();
        cell_item_t it;
        int pool;
        pool = pool_words(order_in_use());
        if ($urandom_range(0, 4) >= 2)
            return random_read_item();
        it = write_beat(0, {$urandom(), $urandom()});
        it.packed_index = IDX_W'($urandom());
        if (pool > 0 && $urandom_range(0, 3) != 0)
            it.packed_index = IDX_W'($urandom_range(0, pool - 1));
        case ($urandom_range(0, 15))
            0: it.word = '0;
            1: it.word = '1;
            2: it.word = SIGN_BIT;
            default: ;
        endcase
        return it;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endtask

    // offer one beat, wait for it to be taken, then update the shadow
    task automatic send_item(input cell_item_t it);
        int gap;
        gap = (send_idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.action       <= it.action;
        item_bus.packed_index <= it.packed_index;
        item_bus.word         <= it.word;
        item_bus.row          <= it.row;
        item_bus.col          <= it.col;
        do @(posedge clk); while (!item_bus.ready);
        if (it.action == ACT_WRITE)
        begin
            if (it.packed_index < pool_words(order_in_use()) && it.packed_index < STORE_DEPTH)
            begin
                packed_words[it.packed_index] = it.word;
                word_written[it.packed_index] = 1'b1;
            end
        end
        else
            pending_cells.push_back(predict_cell_read(it));
    endtask

    // stop offering beats and wait until every expected cell is back
    task automatic drain_results(input int extra);
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_cells.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    // apb write, only once the block has gone quiet
    task automatic write_register(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        drain_results(SETTLE_CYCLES);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_MODE)
            cur_mode = value[0];
        else
            cur_size = value[ORDER_W-1:0];
    endtask

    task automatic set_layout(input logic mode, input int size);
        write_register(REG_MODE, APB_DATA_W'(mode));
        write_register(REG_SIZE, APB_DATA_W'(size));
    endtask

    // word zero and a random spread of packed words before any cell is read
    task automatic test_fill_store();
        send_item(write_beat(0, {$urandom(), $urandom()}));
        for (int i = 1; i < FILL_WORDS; i++)
            send_item(write_beat($urandom_range(0, STORE_DEPTH - 1), {$urandom(), $urandom()}));
    endtask

    task automatic test_directed_cases();
        // symmetric, full order: pool ends, dropped writes, both halves
        send_item(write_beat(0, '1));
        send_item(write_beat(MAX_ORDER - 1, 64'hfedc_ba98_7654_3210));
        send_item(write_beat(STORE_DEPTH - 1, '0));
        send_item(write_beat((1 << IDX_W) - 1, 64'h0123_4567_89ab_cdef));
        send_item(write_beat(STORE_DEPTH, '1));
        send_item(read_beat(0, 0));
        send_item(read_beat(MAX_ORDER - 1, MAX_ORDER - 1));
        send_item(read_beat(MAX_ORDER - 1, 0));
        send_item(read_beat(0, MAX_ORDER - 1));
        // antisymmetric, full order: diagonal, mirror with sign inverted
        set_layout(MODE_ASYM, MAX_ORDER);
        send_item(write_beat(STORE_DEPTH - MAX_ORDER - 1, 64'h7fff_ffff_ffff_ffff));
        send_item(write_beat(STORE_DEPTH - MAX_ORDER, '0));
        send_item(read_beat(5, 5));
        send_item(read_beat(MAX_ORDER - 2, MAX_ORDER - 1));
        send_item(read_beat(MAX_ORDER - 1, MAX_ORDER - 2));
        send_item(read_beat(0, 1));
        // antisymmetric order one has an empty pool
        set_layout(MODE_ASYM, 1);
        send_item(write_beat(0, '1));
        send_item(read_beat(0, 0));
        send_item(read_beat(0, 1));
        // order zero: nothing in range
        set_layout(MODE_SYM, 0);
        send_item(write_beat(0, '0));
        send_item(read_beat(0, 0));
        // order above the maximum saturates
        set_layout(MODE_SYM, (1 << ORDER_W) - 1);
        send_item(read_beat(MAX_ORDER - 1, MAX_ORDER - 1));
        send_item(write_beat(STORE_DEPTH - 1, 64'h8000_0000_0000_0001));
        send_item(read_beat(MAX_ORDER - 1, MAX_ORDER - 1));
        // symmetric order one
        set_layout(MODE_SYM, 1);
        send_item(read_beat(0, 0));
        send_item(read_beat(1, 0));
        send_item(read_beat(MAX_ORDER - 1, MAX_ORDER - 1));
    endtask

    // random beats over a run of layouts, extremes first
    task automatic test_random_layouts();
        int size;
        logic mode;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: size = MAX_ORDER;
                1: size = 1;
                2: size = 2;
                3: size = 0;
                4: size = (1 << ORDER_W) - 1;
                default: size = $urandom_range(1, MAX_ORDER);
            endcase
            mode = (phase < 4) ? phase[0] : logic'($urandom_range(0, 1));
            set_layout(mode, size);
            send_idling = ($urandom_range(0, 3) != 0);
            recv_idling = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(random_cell_item());
        end
        send_idling = 1'b1;
        recv_idling = 1'b1;
    endtask

    // result side held off while reads keep coming, so the input stalls
    task automatic test_input_stall();
        set_layout(MODE_ASYM, MAX_ORDER);
        send_idling  = 1'b0;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
            send_item(random_read_item());
        send_idling = 1'b1;
    endtask

    // sender waits for every result before going on
    task automatic test_drain_pause();
        set_layout(MODE_SYM, $urandom_range(1, MAX_ORDER));
        for (int i = 0; i < 20; i++)
            send_item(random_cell_item());
        drain_results(0);
        for (int i = 0; i < 20; i++)
            send_item(random_cell_item());
    endtask

    // closing stretch at full rate on both sides
    task automatic test_no_idle();
        set_layout(logic'($urandom_range(0, 1)), MAX_ORDER);
        send_idling = 1'b0;
        recv_idling = 1'b0;
        for (int i = 0; i < 100; i++)
            send_item(random_cell_item());
    endtask

    // result side: random stall bursts and the long hold-off
    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else if (recv_idling && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 7);
            else
                stall = 0;
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest expected cell
    always @(posedge clk)
    begin : check_results
        cell_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_cells.size() == 0)
                note_mismatch($sformatf("result with no pending read: cell_value=%h range_error=%b",
                                        result_bus.cell_value, result_bus.range_error));
            else
            begin
                want = pending_cells.pop_front();
                if (result_bus.cell_value !== want.cell_value ||
                    result_bus.range_error !== want.range_error)
                    note_mismatch($sformatf("cell_value exp %h got %h, range_error exp %b got %b",
                                            want.cell_value, result_bus.cell_value,
                                            want.range_error, result_bus.range_error));
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_bus.valid        = 1'b0;
        item_bus.action       = ACT_WRITE;
        item_bus.packed_index = '0;
        item_bus.word         = '0;
        item_bus.row          = '0;
        item_bus.col          = '0;
        cur_mode              = MODE_SYM;
        cur_size              = ORDER_W'(MAX_ORDER);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_fill_store();
        test_directed_cases();
        test_random_layouts();
        test_input_stall();
        test_drain_pause();
        test_no_idle();

        drain_results(END_CYCLES);
        if (mismatch_count == 0 && pending_cells.size() == 0)
            $display("** packed_triangle_cell_reader: PASSED **");
        else
            $display("** packed_triangle_cell_reader: FAILED **");
        $finish;
    end

endmodule

/* files.f */
design/ptcr_pkg.sv
design/ptcr_in_if.sv
design/ptcr_out_if.sv
design/ptcr_ram.sv
design/ptcr_cfg.sv
design/ptcr_front.sv
design/ptcr_back.sv
design/packed_triangle_cell_reader.sv
verif/testbench.sv
